// ===== rtl/crpc_pkg.sv =====
`timescale 1ns / 1ps
// Package: CORDIC constants, arctangent table and stage types for the converter.
package crpc_pkg;

    localparam int DW = 48;   // CORDIC x/y/z datapath width
    localparam int MAX_STEPS = 24;

    localparam logic signed [47:0] INV_GAIN = 48'sd652032874;
    localparam logic signed [47:0] PI_Q30 = 48'sd3373259426;
    localparam logic signed [47:0] HALF_PI_Q30 = 48'sd1686629713;
    localparam logic signed [47:0] TWO_PI_Q30 = 48'sd6746518852;
    localparam logic signed [15:0] PI_Q12 = 16'sd12868;
    localparam logic signed [15:0] HALF_PI_Q12 = 16'sd6434;
    localparam logic signed [15:0] THREE_HALF_PI_Q12 = 16'sd19302;

    typedef logic signed [DW-1:0] t_dat;

    typedef struct packed {
        logic              polar;
        logic              neg;
        logic signed [15:0] a;
        logic signed [15:0] b;
        t_dat              x;
        t_dat              y;
        t_dat              z;
    } t_stage;

    function automatic t_dat atan_tab(input int i);
        case (i)
            0: atan_tab = 48'sd843314856;
            1: atan_tab = 48'sd497837829;
            2: atan_tab = 48'sd263043836;
            3: atan_tab = 48'sd133525158;
            4: atan_tab = 48'sd67021686;
            5: atan_tab = 48'sd33543515;
            6: atan_tab = 48'sd16775850;
            7: atan_tab = 48'sd8388437;
            8: atan_tab = 48'sd4194282;
            9: atan_tab = 48'sd2097149;
            10: atan_tab = 48'sd1048575;
            11: atan_tab = 48'sd524287;
            12: atan_tab = 48'sd262143;
            13: atan_tab = 48'sd131071;
            14: atan_tab = 48'sd65535;
            15: atan_tab = 48'sd32767;
            16: atan_tab = 48'sd16383;
            17: atan_tab = 48'sd8191;
            18: atan_tab = 48'sd4095;
            19: atan_tab = 48'sd2047;
            20: atan_tab = 48'sd1023;
            21: atan_tab = 48'sd511;
            22: atan_tab = 48'sd255;
            23: atan_tab = 48'sd127;
            default: atan_tab = '0;
        endcase
    endfunction

endpackage

// ===== rtl/complex_rect_polar_converter_unit.sv =====
`timescale 1ns / 1ps
// Top level: pipelined CORDIC rectangular/polar converter.
// Input channel: i_valid/o_ready carry one word (form, first and second value).
// Output channel: o_valid/i_ready carry one result word: real, imaginary,
// magnitude, angle and the saturation flag.
// Pipeline: one input stage (angle reduction, gain scaling), ITERATIONS
// CORDIC stages (capped at MAX_STEPS), one gain-multiply stage and one
// rounding stage that is the output register.
// Throughput: one word per cycle. The whole pipeline advances together; it
// holds when the output register is full and i_ready is low, so o_ready is
// low only then. Nothing is lost or repeated on a stall.
// Reset clears all valid bits; payload registers are not reset.
// No state is kept between words.
module complex_rect_polar_converter_unit #(
    parameter int ITERATIONS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_form,
    input  logic signed [15:0] i_first_value,
    input  logic signed [15:0] i_second_value,
    output logic        o_valid,
    input  logic        i_ready,
    output logic signed [15:0] o_real_value,
    output logic signed [15:0] o_imag_value,
    output logic signed [15:0] o_mag_value,
    output logic signed [15:0] o_angle_value,
    output logic        o_saturated
);
    import crpc_pkg::*;

    localparam int STEPS = (ITERATIONS > MAX_STEPS) ? MAX_STEPS : ITERATIONS;

    logic en;
    assign en = !o_valid || i_ready;
    assign o_ready = en;

    // input stage
    t_stage n_in;
    t_dat   zin;
    t_dat   xs;
    logic   neg;
    always_comb begin
        zin = t_dat'(i_second_value) <<< 18;
        if (zin > PI_Q30) zin = zin - TWO_PI_Q30;
        if (zin < -PI_Q30) zin = zin + TWO_PI_Q30;
        neg = 1'b0;
        if (zin > HALF_PI_Q30) begin
            zin = zin - PI_Q30;
            neg = 1'b1;
        end else if (zin < -HALF_PI_Q30) begin
            zin = zin + PI_Q30;
            neg = 1'b1;
        end
        xs = (t_dat'(i_first_value) * INV_GAIN + t_dat'(48'sd8192)) >>> 14;
        n_in.polar = i_form;
        n_in.neg   = neg;
        n_in.a     = i_first_value;
        n_in.b     = i_second_value;
        if (i_form) begin
            n_in.x = xs;
            n_in.y = '0;
            n_in.z = zin;
        end else begin
            n_in.x = i_first_value[15] ? -(t_dat'(i_first_value) <<< 16)
                                       : (t_dat'(i_first_value) <<< 16);
            n_in.y = i_first_value[15] ? -(t_dat'(i_second_value) <<< 16)
                                       : (t_dat'(i_second_value) <<< 16);
            n_in.z = '0;
        end
    end

    logic   v [0:STEPS];
    t_stage d [0:STEPS];
    logic   r_v0;
    t_stage r_d0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (en) begin
            r_v0 <= i_valid;
        end
        if (en) begin
            r_d0 <= n_in;
        end
    end

    assign v[0] = r_v0;
    assign d[0] = r_d0;

    for (genvar g = 0; g < STEPS; g++) begin : g_cordic
        crpc_stage #(.STEP(g)) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (v[g]),
            .i_data  (d[g]),
            .o_valid (v[g+1]),
            .o_data  (d[g+1])
        );
    end

    // gain multiply (vectoring) and angle offset
    logic        r_mv;
    t_stage      r_md;
    logic [63:0] r_prod;
    logic        r_big;
    t_dat        r_zoff;
    t_stage      f;
    t_dat        ux;
    always_comb begin
        f  = d[STEPS];
        ux = f.x[DW-1] ? '0 : f.x;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv <= 1'b0;
        end else if (en) begin
            r_mv <= v[STEPS];
        end
        if (en) begin
            r_md   <= f;
            r_prod <= 64'(ux[31:0]) * 64'(INV_GAIN[31:0]);
            r_big  <= |ux[DW-1:32];
            r_zoff <= f.a[15] ? f.z + PI_Q30 : f.z;
        end
    end

    // rounding and selection
    logic        r_ov;
    logic signed [15:0] r_re, r_im, r_mag, r_ang;
    logic        r_sat;
    logic [63:0] mg;
    t_dat        xr, yr, zr;
    logic signed [15:0] n_re, n_im, n_mag, n_ang;
    logic        n_sat;
    always_comb begin
        mg = (r_prod + (64'd1 << 45)) >> 46;
        xr = r_md.neg ? -r_md.x : r_md.x;
        yr = r_md.neg ? -r_md.y : r_md.y;
        xr = (xr + t_dat'(48'sd32768)) >>> 16;
        yr = (yr + t_dat'(48'sd32768)) >>> 16;
        zr = (r_zoff + t_dat'(48'sd131072)) >>> 18;
        n_sat = 1'b0;
        if (r_md.polar) begin
            n_re  = (xr > 48'sd32767) ? 16'sd32767 :
                    (xr < -48'sd32768) ? -16'sd32768 : xr[15:0];
            n_im  = (yr > 48'sd32767) ? 16'sd32767 :
                    (yr < -48'sd32768) ? -16'sd32768 : yr[15:0];
            n_mag = r_md.a;
            n_ang = r_md.b;
        end else begin
            n_re = r_md.a;
            n_im = r_md.b;
            if (r_big || mg > 64'd32767) begin
                n_mag = 16'sd32767;
                n_sat = 1'b1;
            end else begin
                n_mag = mg[15:0];
            end
            if (r_md.a != 16'sd0) n_ang = zr[15:0];
            else if (r_md.b > 16'sd0) n_ang = THREE_HALF_PI_Q12;
            else if (r_md.b < 16'sd0) n_ang = HALF_PI_Q12;
            else n_ang = PI_Q12;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en) begin
            r_ov <= r_mv;
        end
        if (en) begin
            r_re  <= n_re;
            r_im  <= n_im;
            r_mag <= n_mag;
            r_ang <= n_ang;
            r_sat <= n_sat;
        end
    end

    assign o_valid       = r_ov;
    assign o_real_value  = r_re;
    assign o_imag_value  = r_im;
    assign o_mag_value   = r_mag;
    assign o_angle_value = r_ang;
    assign o_saturated   = r_sat;
endmodule

// ===== rtl/crpc_stage.sv =====
`timescale 1ns / 1ps
// One registered CORDIC micro-rotation, vectoring or rotation by the form bit.
module crpc_stage #(
    parameter int STEP = 0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  crpc_pkg::t_stage i_data,
    output logic           o_valid,
    output crpc_pkg::t_stage o_data
);
    import crpc_pkg::*;

    logic   r_valid;
    t_stage r_data;
    t_stage n_data;
    t_dat   dx;
    t_dat   dy;
    logic   up;

    always_comb begin
        n_data = i_data;
        dx = i_data.y >>> STEP;
        dy = i_data.x >>> STEP;
        up = i_data.polar ? !i_data.z[DW-1] : !i_data.y[DW-1];
        if (i_data.polar) begin
            if (up) begin
                n_data.x = i_data.x - dx;
                n_data.y = i_data.y + dy;
                n_data.z = i_data.z - atan_tab(STEP);
            end else begin
                n_data.x = i_data.x + dx;
                n_data.y = i_data.y - dy;
                n_data.z = i_data.z + atan_tab(STEP);
            end
        end else begin
            if (up) begin
                n_data.x = i_data.x + dx;
                n_data.y = i_data.y - dy;
                n_data.z = i_data.z + atan_tab(STEP);
            end else begin
                n_data.x = i_data.x - dx;
                n_data.y = i_data.y + dy;
                n_data.z = i_data.z - atan_tab(STEP);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
endmodule

// ===== dv/complex_rect_polar_converter_unit_tb.sv =====
`timescale 1ns / 1ps
// Testbench: random and directed stimulus for the CORDIC rectangular/polar converter.
module complex_rect_polar_converter_unit_tb;
    import crpc_pkg::*;

    localparam int STEPS = 16;
    localparam int LATENCY = STEPS + 4;
    localparam int N_RANDOM = 1450;
    localparam int CYCLE_LIMIT = 200000;
    localparam logic FORM_RECT = 1'b0;
    localparam logic FORM_POLAR = 1'b1;

    typedef struct packed {
        logic form;
        logic signed [15:0] a;
        logic signed [15:0] b;
    } t_word;

    typedef struct packed {
        logic signed [15:0] re;
        logic signed [15:0] im;
        logic signed [15:0] mag;
        logic signed [15:0] ang;
        logic sat;
    } t_conv;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_form = 1'b0;
    logic signed [15:0] i_first_value = '0;
    logic signed [15:0] i_second_value = '0;
    logic i_ready = 1'b0;
    logic o_ready, o_valid, o_saturated;
    logic signed [15:0] o_real_value, o_imag_value, o_mag_value, o_angle_value;

    t_word pending_words[$];
    t_conv expected_convs[$];
    int errors = 0;
    int cycles = 0;
    bit stim_done = 0;
    int hold_off = 0;

    complex_rect_polar_converter_unit #(.ITERATIONS(STEPS)) dut (.*);

    always #4 i_clk = ~i_clk;

    function automatic longint floor_shr(longint v, int sh);
        return v >>> sh;
    endfunction

    function automatic longint round_shr(longint v, int sh);
        return (v + (longint'(1) << (sh - 1))) >>> sh;
    endfunction

    function automatic longint clip(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic t_conv convert(t_word w);
        t_conv r;
        longint a, b, x, y, z, dx, dy, m;
        bit neg;
        a = w.a;
        b = w.b;
        r.sat = 1'b0;
        if (w.form == FORM_RECT) begin
            x = (a < 0 ? -a : a) * 65536;
            y = (a < 0 ? -b : b) * 65536;
            z = 0;
            for (int i = 0; i < STEPS; i++) begin
                dx = floor_shr(y, i);
                dy = floor_shr(x, i);
                if (y >= 0) begin
                    x += dx; y -= dy; z += longint'(atan_tab(i));
                end else begin
                    x -= dx; y += dy; z -= longint'(atan_tab(i));
                end
            end
            if (x < 0) x = 0;
            m = (x * longint'(INV_GAIN) + (longint'(1) << 45)) >>> 46;
            if (m > 32767) begin
                m = 32767;
                r.sat = 1'b1;
            end
            r.mag = 16'(m);
            if (a > 0) r.ang = 16'(round_shr(z, 18));
            else if (a < 0) r.ang = 16'(round_shr(z + longint'(PI_Q30), 18));
            else if (b > 0) r.ang = THREE_HALF_PI_Q12;
            else if (b < 0) r.ang = HALF_PI_Q12;
            else r.ang = PI_Q12;
            r.re = w.a;
            r.im = w.b;
        end else begin
            z = b * 262144;
            y = 0;
            neg = 0;
            while (z > longint'(PI_Q30)) z -= longint'(TWO_PI_Q30);
            while (z < -longint'(PI_Q30)) z += longint'(TWO_PI_Q30);
            if (z > longint'(HALF_PI_Q30)) begin
                z -= longint'(PI_Q30); neg = 1;
            end else if (z < -longint'(HALF_PI_Q30)) begin
                z += longint'(PI_Q30); neg = 1;
            end
            x = round_shr(a * longint'(INV_GAIN), 14);
            for (int i = 0; i < STEPS; i++) begin
                dx = floor_shr(y, i);
                dy = floor_shr(x, i);
                if (z >= 0) begin
                    x -= dx; y += dy; z -= longint'(atan_tab(i));
                end else begin
                    x += dx; y -= dy; z += longint'(atan_tab(i));
                end
            end
            if (neg) begin
                x = -x; y = -y;
            end
            r.re = 16'(clip(round_shr(x, 16)));
            r.im = 16'(clip(round_shr(y, 16)));
            r.mag = w.a;
            r.ang = w.b;
        end
        return r;
    endfunction

    function automatic logic signed [15:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return '0;
            3: return 16'($urandom_range(0, 8)) - 16'sd4;
            4: return 16'($urandom_range(0, 16383)) - 16'sd8192;
            default: return 16'($urandom);
        endcase
    endfunction

    // driver: bursts with random gaps
    int burst = 0;
    int gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (i_valid && !o_ready) begin
        end else begin
            if (i_valid) begin
                expected_convs.push_back(convert({i_form, i_first_value, i_second_value}));
            end
            if (gap > 0) begin
                gap <= gap - 1;
                i_valid <= 1'b0;
            end else if (pending_words.size() > 0) begin
                t_word w;
                w = pending_words.pop_front();
                i_valid <= 1'b1;
                i_form <= w.form;
                i_first_value <= w.a;
                i_second_value <= w.b;
                if (burst == 0) begin
                    burst <= $urandom_range(1, 40);
                    gap <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
                end else begin
                    burst <= burst - 1;
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver stall pattern and one long hold-off
    always @(posedge i_clk) begin
        if (cycles == 400) begin
            hold_off <= 300;
            i_ready <= 1'b0;
        end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            i_ready <= 1'b0;
        end else if ((cycles / 512) % 3 == 0) begin
            i_ready <= 1'b1;
        end else begin
            i_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_convs.size() == 0) begin
                $error("unexpected result word");
                errors++;
            end else begin
                t_conv e;
                e = expected_convs.pop_front();
                if (o_real_value !== e.re) begin
                    $error("real_value exp %0d got %0d", e.re, o_real_value); errors++;
                end
                if (o_imag_value !== e.im) begin
                    $error("imag_value exp %0d got %0d", e.im, o_imag_value); errors++;
                end
                if (o_mag_value !== e.mag) begin
                    $error("mag_value exp %0d got %0d", e.mag, o_mag_value); errors++;
                end
                if (o_angle_value !== e.ang) begin
                    $error("angle_value exp %0d got %0d", e.ang, o_angle_value); errors++;
                end
                if (o_saturated !== e.sat) begin
                    $error("saturated exp %0d got %0d", e.sat, o_saturated); errors++;
                end
            end
        end
        if (cycles >= CYCLE_LIMIT) begin
            $display("complex_rect_polar_converter_unit_tb failed");
            $finish;
        end
    end

    initial begin
        t_word w;
        logic signed [15:0] edges[6] = '{16'sh7fff, 16'sh8000, 16'sd0, 16'sd1, -16'sd1,
                                         16'sd4096};
        // directed: zero real part, overflow, angle wrap, negative magnitude
        pending_words.push_back({FORM_RECT, 16'sd0, 16'sd100});
        pending_words.push_back({FORM_RECT, 16'sd0, -16'sd100});
        pending_words.push_back({FORM_RECT, 16'sd0, 16'sd0});
        pending_words.push_back({FORM_RECT, 16'sh7fff, 16'sh7fff});
        pending_words.push_back({FORM_RECT, 16'sh8000, 16'sh8000});
        pending_words.push_back({FORM_RECT, -16'sd4096, 16'sd4096});
        pending_words.push_back({FORM_RECT, -16'sd4096, -16'sd4096});
        pending_words.push_back({FORM_RECT, 16'sd4096, 16'sh8000});
        pending_words.push_back({FORM_POLAR, 16'sh7fff, 16'sd0});
        pending_words.push_back({FORM_POLAR, 16'sh8000, 16'sd12868});
        pending_words.push_back({FORM_POLAR, 16'sh7fff, 16'sh7fff});
        pending_words.push_back({FORM_POLAR, 16'sh7fff, 16'sh8000});
        pending_words.push_back({FORM_POLAR, 16'sh7fff, 16'sd6434});
        pending_words.push_back({FORM_POLAR, -16'sd4096, -16'sd6435});
        pending_words.push_back({FORM_POLAR, 16'sh7fff, 16'sd4000});
        pending_words.push_back({FORM_POLAR, 16'sd0, 16'sd1000});
        for (int k = 0; k < 6; k++) begin
            pending_words.push_back({FORM_RECT, edges[k], edges[5 - k]});
        end
        for (int n = 0; n < N_RANDOM; n++) begin
            w.form = 1'($urandom_range(0, 1));
            w.a = pick_value();
            w.b = pick_value();
            pending_words.push_back(w);
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (pending_words.size() == 0);
        @(posedge i_clk);
        wait (!i_valid && expected_convs.size() == 0);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (errors == 0 && expected_convs.size() == 0) begin
            $display("complex_rect_polar_converter_unit_tb passed");
        end else begin
            $display("complex_rect_polar_converter_unit_tb failed");
        end
        $finish;
    end
endmodule
